FILE: hw/rtl/rcd_pkg.sv
// Shared types and constants of the response chunk deframer.
`default_nettype none
package rcd_pkg;

    localparam int PAYLOAD_TRIPLETS_DEF = 16;
    localparam int HEADER_MIN_DEF       = 6;
    localparam int HDR_BYTES            = 6;
    localparam int EVT_DEPTH            = 2;

    localparam logic [7:0] HDR_SYNC0   = 8'h20;
    localparam logic [7:0] HDR_SYNC1   = 8'hA2;
    localparam logic [7:0] RC_TIMEOUT  = 8'h02;
    localparam logic [7:0] RC_GOOD     = 8'h01;
    localparam logic [7:0] HDR_TYPE    = 8'h05;
    localparam logic [7:0] HDR_VER     = 8'h01;
    localparam logic [7:0] TRIPLET_TAG = 8'h02;

    typedef enum logic [2:0] {
        STS_OK      = 3'd0,
        STS_DONE    = 3'd1,
        STS_SIZE    = 3'd2,
        STS_FORMAT  = 3'd3,
        STS_TIMEOUT = 3'd4,
        STS_RETURN  = 3'd5,
        STS_PAYLOAD = 3'd6
    } t_status;

    // Event handed from the parser to the result side.
    typedef struct packed {
        logic        has_val;
        logic [15:0] word;
        logic        is_end;
        logic        emit;
        t_status     status;
    } t_evt;

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_LOAD,
        B_STAT
    } t_bstate;

endpackage
`default_nettype wire

FILE: hw/rtl/response_chunk_deframer_top.sv
// Response chunk deframer: top level joining parser, event queue and result side.
//
// Bytes of a chunk are taken one per cycle while the two-entry event queue has
// room; the parser checks the header, the length and the payload triplets on
// the fly and hands decoded values and one end-of-chunk event to the result
// side. On the last byte of a chunk with good header and length, the buffered
// values are emitted in arrival order, followed by one status item with
// run_end set; other chunks yield only the status item. The result side
// reads the value buffer through a registered port, so each value passes the
// B_READ and B_LOAD states to reach the output register, and the status item
// then B_STAT; while a chunk end drains, input bytes keep flowing until the event
// queue fills. full rises only while the queue holds two unprocessed events.
`default_nettype none
module response_chunk_deframer_top #(
    parameter int PAYLOAD_TRIPLETS = rcd_pkg::PAYLOAD_TRIPLETS_DEF,
    parameter int HEADER_MIN       = rcd_pkg::HEADER_MIN_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         push,
    output logic              full,
    input  wire logic [7:0]   i_data_byte,
    input  wire logic         i_last_byte,
    output logic              empty,
    input  wire logic         pop,
    output logic              o_is_status,
    output logic [15:0]       o_value_word,
    output logic [2:0]        o_status_code,
    output logic              o_run_end
);

    rcd_pkg::t_evt  f_evt, q_evt;
    logic           f_push, q_full, q_empty, q_pop;

    rcd_front #(
        .PAYLOAD_TRIPLETS (PAYLOAD_TRIPLETS),
        .HEADER_MIN       (HEADER_MIN)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_q_full    (q_full),
        .o_evt       (f_evt),
        .o_evt_push  (f_push)
    );

    rcd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_evt   (f_evt),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_evt   (q_evt),
        .o_empty (q_empty)
    );

    rcd_back #(
        .PAYLOAD_TRIPLETS (PAYLOAD_TRIPLETS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_evt         (q_evt),
        .i_q_empty     (q_empty),
        .o_q_pop       (q_pop),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_is_status   (o_is_status),
        .o_value_word  (o_value_word),
        .o_status_code (o_status_code),
        .o_run_end     (o_run_end)
    );

    assign full = q_full;

endmodule
`default_nettype wire

FILE: hw/rtl/rcd_front.sv
// Byte parser: header checks, triplet decoding and end-of-chunk status.
`default_nettype none
module rcd_front #(
    parameter int PAYLOAD_TRIPLETS = rcd_pkg::PAYLOAD_TRIPLETS_DEF,
    parameter int HEADER_MIN       = rcd_pkg::HEADER_MIN_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [7:0]   i_data_byte,
    input  wire logic         i_last_byte,
    input  wire logic         i_q_full,
    output rcd_pkg::t_evt     o_evt,
    output logic              o_evt_push
);

    localparam int CHUNK = rcd_pkg::HDR_BYTES + 3 * PAYLOAD_TRIPLETS;
    localparam int POS_W = $clog2(CHUNK + 2);

    logic [POS_W-1:0]  r_pos, n_pos;
    rcd_pkg::t_status  r_herr, n_herr;
    logic              r_endm, n_endm;
    logic [7:0]        r_high, n_high;
    logic              r_bad, n_bad;
    logic [1:0]        r_phase, n_phase;
    logic              acc;
    rcd_pkg::t_evt     evt;

    assign acc = i_push && !i_q_full;

    always_comb begin
        n_pos   = r_pos;
        n_herr  = r_herr;
        n_endm  = r_endm;
        n_high  = r_high;
        n_bad   = r_bad;
        n_phase = r_phase;
        evt     = '0;
        evt.status = rcd_pkg::STS_OK;
        if (acc) begin
            if (r_pos >= POS_W'(CHUNK)) begin
                // overlong chunk: saturate and ignore the byte
                n_pos = POS_W'(CHUNK + 1);
            end else begin
                n_pos = r_pos + 1'b1;
                if (r_pos == POS_W'(0)) begin
                    if (i_data_byte != rcd_pkg::HDR_SYNC0 && r_herr == rcd_pkg::STS_OK)
                        n_herr = rcd_pkg::STS_FORMAT;
                end else if (r_pos == POS_W'(1)) begin
                    if (i_data_byte != rcd_pkg::HDR_SYNC1 && r_herr == rcd_pkg::STS_OK)
                        n_herr = rcd_pkg::STS_FORMAT;
                end else if (r_pos == POS_W'(2)) begin
                    if (r_herr == rcd_pkg::STS_OK) begin
                        if (i_data_byte == rcd_pkg::RC_TIMEOUT)
                            n_herr = rcd_pkg::STS_TIMEOUT;
                        else if (i_data_byte != rcd_pkg::RC_GOOD)
                            n_herr = rcd_pkg::STS_RETURN;
                    end
                end else if (r_pos == POS_W'(3)) begin
                    if (i_data_byte != rcd_pkg::HDR_TYPE && r_herr == rcd_pkg::STS_OK)
                        n_herr = rcd_pkg::STS_FORMAT;
                end else if (r_pos == POS_W'(4)) begin
                    if (i_data_byte != rcd_pkg::HDR_VER && r_herr == rcd_pkg::STS_OK)
                        n_herr = rcd_pkg::STS_FORMAT;
                end else if (r_pos == POS_W'(5)) begin
                    n_endm = (i_data_byte == 8'h00);
                end else begin
                    case (r_phase)
                        2'd0: begin
                            if (i_data_byte != rcd_pkg::TRIPLET_TAG) n_bad = 1'b1;
                            n_phase = 2'd1;
                        end
                        2'd1: begin
                            n_high  = i_data_byte;
                            n_phase = 2'd2;
                        end
                        default: begin
                            evt.has_val = !r_bad;
                            evt.word    = {r_high, i_data_byte};
                            n_phase     = 2'd0;
                        end
                    endcase
                end
            end

            if (i_last_byte) begin
                evt.is_end = 1'b1;
                if (n_pos < POS_W'(HEADER_MIN)) begin
                    evt.status = rcd_pkg::STS_SIZE;
                end else if (n_herr != rcd_pkg::STS_OK) begin
                    evt.status = n_herr;
                end else if (n_pos != POS_W'(CHUNK)) begin
                    evt.status = rcd_pkg::STS_FORMAT;
                end else begin
                    evt.emit = 1'b1;
                    if (n_bad)       evt.status = rcd_pkg::STS_PAYLOAD;
                    else if (n_endm) evt.status = rcd_pkg::STS_DONE;
                    else             evt.status = rcd_pkg::STS_OK;
                end
                // clear for the next chunk
                n_pos   = '0;
                n_herr  = rcd_pkg::STS_OK;
                n_endm  = 1'b0;
                n_high  = '0;
                n_bad   = 1'b0;
                n_phase = 2'd0;
            end
        end
    end

    assign o_evt      = evt;
    assign o_evt_push = acc && (evt.has_val || evt.is_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_herr  <= rcd_pkg::STS_OK;
            r_endm  <= 1'b0;
            r_high  <= '0;
            r_bad   <= 1'b0;
            r_phase <= 2'd0;
        end else begin
            r_pos   <= n_pos;
            r_herr  <= n_herr;
            r_endm  <= n_endm;
            r_high  <= n_high;
            r_bad   <= n_bad;
            r_phase <= n_phase;
        end
    end

`ifndef SYNTHESIS
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(CHUNK + 1))
        else $error("byte position out of range");
    a_phase_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos < POS_W'(rcd_pkg::HDR_BYTES + 1)) |-> (r_phase == 2'd0))
        else $error("triplet phase moved inside header");
    a_chunk_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_last_byte) |=> (r_pos == '0 && r_herr == rcd_pkg::STS_OK && !r_bad))
        else $error("parser state not cleared after last byte");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/rcd_fifo.sv
// Short event queue between the parser and the result side.
`default_nettype none
module rcd_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire rcd_pkg::t_evt i_evt,
    output logic               o_full,
    input  wire logic          i_pop,
    output rcd_pkg::t_evt      o_evt,
    output logic               o_empty
);

    localparam int DEPTH = rcd_pkg::EVT_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rcd_pkg::t_evt     r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [CNT_W-1:0]  r_cnt;
    logic              wr_en, rd_en;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_evt   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[r_wr] <= i_evt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            if (rd_en) r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            r_cnt <= r_cnt + CNT_W'(wr_en) - CNT_W'(rd_en);
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("queue count overflow");
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("event pushed into full queue");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0 || r_cnt == CNT_W'(DEPTH)) |-> (r_wr == r_rd))
        else $error("queue pointers disagree with count");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/rcd_back.sv
// Result side: buffers values and drains them with the status at chunk end (status only if the chunk is not emitted).
`default_nettype none
module rcd_back #(
    parameter int PAYLOAD_TRIPLETS = rcd_pkg::PAYLOAD_TRIPLETS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire rcd_pkg::t_evt i_evt,
    input  wire logic          i_q_empty,
    output logic               o_q_pop,
    output logic               o_empty,
    input  wire logic          i_pop,
    output logic               o_is_status,
    output logic [15:0]        o_value_word,
    output logic [2:0]         o_status_code,
    output logic               o_run_end
);

    localparam int IDX_W = (PAYLOAD_TRIPLETS > 1) ? $clog2(PAYLOAD_TRIPLETS) : 1;
    localparam int CNT_W = $clog2(PAYLOAD_TRIPLETS + 1);

    logic [15:0]       r_mem [PAYLOAD_TRIPLETS];
    logic [15:0]       r_rd_data;
    logic [CNT_W-1:0]  r_wr_cnt, r_drain_cnt, r_rd_idx;
    rcd_pkg::t_status  r_status;
    rcd_pkg::t_bstate  r_state, n_state;

    logic              r_out_valid;
    logic              r_is_status;
    logic [15:0]       r_word;
    rcd_pkg::t_status  r_code;
    logic              r_run_end;

    logic              out_free, q_take, wr_en, rd_en, load_val, load_stat;
    logic [CNT_W-1:0]  end_cnt;

    assign out_free = !r_out_valid || i_pop;
    assign wr_en    = q_take && i_evt.has_val;
    assign end_cnt  = r_wr_cnt + CNT_W'(i_evt.has_val);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rcd_pkg::B_IDLE: begin
                if (!i_q_empty && i_evt.is_end) begin
                    n_state = (i_evt.emit && end_cnt != '0) ? rcd_pkg::B_READ
                                                            : rcd_pkg::B_STAT;
                end
            end
            rcd_pkg::B_READ: n_state = rcd_pkg::B_LOAD;
            rcd_pkg::B_LOAD: begin
                if (out_free) begin
                    n_state = (r_rd_idx + 1'b1 == r_drain_cnt) ? rcd_pkg::B_STAT
                                                               : rcd_pkg::B_READ;
                end
            end
            rcd_pkg::B_STAT: if (out_free) n_state = rcd_pkg::B_IDLE;
            default: n_state = rcd_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        q_take    = 1'b0;
        rd_en     = 1'b0;
        load_val  = 1'b0;
        load_stat = 1'b0;
        unique case (r_state)
            rcd_pkg::B_IDLE: q_take    = !i_q_empty;
            rcd_pkg::B_READ: rd_en     = 1'b1;
            rcd_pkg::B_LOAD: load_val  = out_free;
            rcd_pkg::B_STAT: load_stat = out_free;
            default: ;
        endcase
    end

    assign o_q_pop = q_take;

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[r_wr_cnt[IDX_W-1:0]] <= i_evt.word;
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) r_rd_data <= r_mem[r_rd_idx[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rcd_pkg::B_IDLE;
            r_wr_cnt    <= '0;
            r_drain_cnt <= '0;
            r_rd_idx    <= '0;
            r_status    <= rcd_pkg::STS_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (q_take) begin
                if (i_evt.is_end) begin
                    r_wr_cnt    <= '0;
                    r_drain_cnt <= end_cnt;
                    r_rd_idx    <= '0;
                    r_status    <= i_evt.status;
                end else if (i_evt.has_val) begin
                    r_wr_cnt <= r_wr_cnt + 1'b1;
                end
            end
            if (load_val) r_rd_idx <= r_rd_idx + 1'b1;
            if (load_val || load_stat) r_out_valid <= 1'b1;
            else if (i_pop)            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_val) begin
            r_is_status <= 1'b0;
            r_word      <= r_rd_data;
            r_code      <= rcd_pkg::STS_OK;
            r_run_end   <= 1'b0;
        end else if (load_stat) begin
            r_is_status <= 1'b1;
            r_word      <= '0;
            r_code      <= r_status;
            r_run_end   <= 1'b1;
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_is_status   = r_is_status;
    assign o_value_word  = r_word;
    assign o_status_code = r_code;
    assign o_run_end     = r_run_end;

`ifndef SYNTHESIS
    a_wr_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_cnt <= CNT_W'(PAYLOAD_TRIPLETS))
        else $error("value buffer overfilled");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != rcd_pkg::B_IDLE) |-> !o_q_pop)
        else $error("event taken while draining");
    a_rd_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rcd_pkg::B_READ || r_state == rcd_pkg::B_LOAD)
            |-> (r_rd_idx < r_drain_cnt))
        else $error("drain index past buffered values");
    a_stat_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_stat |=> (r_state == rcd_pkg::B_IDLE && r_wr_cnt == '0))
        else $error("status sent with values still pending");
`endif

endmodule
`default_nettype wire
